>>> src/ghc_pkg.sv
package ghc_pkg;

  localparam int unsigned MAX_BLOCK_BYTES_DEF = 4096;
  localparam int unsigned CFG_W               = 13;
  localparam int unsigned LBA_W               = 64;
  localparam int unsigned LEN_W               = 32;

  localparam logic [CFG_W-1:0] MIN_LEN_RESET  = 13'd92;
  localparam logic [31:0]      CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0]      CRC_INIT       = 32'hFFFFFFFF;

  // header layout, byte offsets
  localparam int unsigned SIG_END     = 8;
  localparam int unsigned LEN_START   = 12;
  localparam int unsigned CRC_START   = 16;
  localparam int unsigned CRC_END     = 20;
  localparam int unsigned LBA_START   = 24;
  localparam int unsigned LBA_END     = 32;
  localparam int unsigned MIN_BLOCK   = 32;
  localparam int unsigned MIN_HDR_LEN = 20;

  typedef logic [7:0] byte_t;
  typedef byte_t sig_t [SIG_END];

  // "EFI PART"
  localparam sig_t SIG_TEXT = '{8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54};

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input byte_t b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/ghc_if.sv
interface ghc_in_if;
  import ghc_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic             last;
  logic [LBA_W-1:0] expected_lba;

  modport source (output valid, output data_byte, output last, output expected_lba,
                  input ready);
  modport sink   (input valid, input data_byte, input last, input expected_lba,
                  output ready);
endinterface

interface ghc_out_if;
  logic valid;
  logic ready;
  logic header_valid;

  modport source (output valid, output header_valid, input ready);
  modport sink   (input valid, input header_valid, output ready);
endinterface

interface ghc_cfg_if;
  import ghc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/gpt_header_checker.sv
// Channel   Dir  Payload                                  Beat when
// in_ch     in   data_byte[7:0], last, expected_lba[63:0] valid && ready
// out_ch    out  header_valid                             valid && ready
// cfg_ch    in   data[12:0] (min_header_length)           valid && ready
//
// One byte per cycle sustained while no verdict waits: an input register, then
// CRC and field update into the block state; the verdict enters the output
// register as the last byte leaves the input register. cfg_ch is always ready.
// Reset (rst_n low, synchronous) clears the block state and sets the register to 92.
// A waiting verdict stalls only a following last byte in the input register.
module gpt_header_checker #(
  parameter int unsigned MAX_BLOCK_BYTES = ghc_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ghc_in_if.sink    in_ch,
  ghc_out_if.source out_ch,
  ghc_cfg_if.sink   cfg_ch
);
  import ghc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BLOCK_BYTES + 1);

  logic [CFG_W-1:0] min_len_r;

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  logic [LBA_W-1:0] s1_lba_r;

  logic [CW-1:0]    count_r,  count_nxt;
  logic [31:0]      crc_r,    crc_nxt;
  logic [LEN_W-1:0] hlen_r,   hlen_nxt;
  logic [31:0]      scrc_r,   scrc_nxt;
  logic [LBA_W-1:0] hlba_r,   hlba_nxt;
  logic [LBA_W-1:0] wlba_r,   wlba_nxt;
  logic             sig_ok_r, sig_ok_nxt;
  logic             ovf_r,    ovf_nxt;

  logic out_valid_r;
  logic out_hv_r;

  logic s1_adv;
  logic ok;

  logic [LEN_W-1:0] i_ext;
  logic [LEN_W-1:0] size_ext;
  logic [LEN_W-1:0] min_ext;

  assign cfg_ch.ready = 1'b1;

  // a last byte waits only while an untaken verdict sits in the output register
  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.header_valid = out_hv_r;

  assign i_ext    = LEN_W'(count_r);
  assign size_ext = LEN_W'(count_nxt);
  assign min_ext  = LEN_W'(min_len_r);

  always_comb begin
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    hlen_nxt   = hlen_r;
    scrc_nxt   = scrc_r;
    hlba_nxt   = hlba_r;
    wlba_nxt   = wlba_r;
    sig_ok_nxt = sig_ok_r;
    ovf_nxt    = ovf_r;

    if (count_r == '0) begin
      wlba_nxt = s1_lba_r;
    end
    if (count_r >= CW'(MAX_BLOCK_BYTES)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (count_r < CW'(SIG_END) && s1_byte_r != SIG_TEXT[count_r[2:0]]) begin
        sig_ok_nxt = 1'b0;
      end
      if (count_r >= CW'(LEN_START) && count_r < CW'(CRC_START)) begin
        hlen_nxt[{count_r[1:0], 3'b000} +: 8] = s1_byte_r;
      end
      if (count_r >= CW'(CRC_START) && count_r < CW'(CRC_END)) begin
        scrc_nxt[{count_r[1:0], 3'b000} +: 8] = s1_byte_r;
      end
      if (count_r >= CW'(LBA_START) && count_r < CW'(LBA_END)) begin
        hlba_nxt[{count_r[2:0], 3'b000} +: 8] = s1_byte_r;
      end
      if (count_r < CW'(CRC_START) || i_ext < hlen_r) begin
        // stored CRC field counts as zeros
        crc_nxt = crc_byte(crc_r,
                           (count_r >= CW'(CRC_START) && count_r < CW'(CRC_END)) ?
                           8'd0 : s1_byte_r);
      end
      count_nxt = count_r + CW'(1);
    end

    ok = !ovf_nxt
      && size_ext >= LEN_W'(MIN_BLOCK) && size_ext >= min_ext
      && sig_ok_nxt
      && hlen_nxt >= LEN_W'(MIN_HDR_LEN)
      && hlen_nxt >= min_ext
      && hlen_nxt <= size_ext
      && (crc_nxt ^ CRC_INIT) == scrc_nxt
      && hlba_nxt == wlba_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_ch.valid) begin
      min_len_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // input register payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last;
      s1_lba_r  <= in_ch.expected_lba;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      crc_r    <= CRC_INIT;
      hlen_r   <= '0;
      scrc_r   <= '0;
      hlba_r   <= '0;
      wlba_r   <= '0;
      sig_ok_r <= 1'b1;
      ovf_r    <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        // restart for the next block
        count_r  <= '0;
        crc_r    <= CRC_INIT;
        hlen_r   <= '0;
        scrc_r   <= '0;
        hlba_r   <= '0;
        wlba_r   <= '0;
        sig_ok_r <= 1'b1;
        ovf_r    <= 1'b0;
      end else begin
        count_r  <= count_nxt;
        crc_r    <= crc_nxt;
        hlen_r   <= hlen_nxt;
        scrc_r   <= scrc_nxt;
        hlba_r   <= hlba_nxt;
        wlba_r   <= wlba_nxt;
        sig_ok_r <= sig_ok_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_hv_r <= ok;
    end
  end

endmodule
